### rtl/ibt_pkg.sv
// shared types and constants for the interval booking table
`default_nettype none
package ibt_pkg;

  localparam int unsigned DefTableEntries = 16;
  localparam int unsigned DefTimeBits     = 32;
  localparam int unsigned InTimeW         = 32;
  localparam int unsigned UsedW           = 5;

  typedef enum logic [1:0] {
    ST_BOOKED  = 2'd0,
    ST_OVERLAP = 2'd1,
    ST_FULL    = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  typedef struct packed {
    logic active;
    logic clash;
    logic free_seen;
  } tok_t;

endpackage
`default_nettype wire

### rtl/ibt_cell.sv
// one table entry: compares the passing request and marks itself as insert target
`default_nettype none
module ibt_cell #(
  parameter int unsigned TIME_BITS = ibt_pkg::DefTimeBits
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [TIME_BITS-1:0] req_start,
  input  wire logic [TIME_BITS-1:0] req_end,
  input  wire ibt_pkg::tok_t        tok_in,
  output ibt_pkg::tok_t             tok_out,
  input  wire logic                 commit,
  output logic                      slot_valid,
  output logic                      slot_cand
);

  logic                 valid_r;
  logic                 cand_r;
  logic                 cand_nxt;
  logic [TIME_BITS-1:0] start_r;
  logic [TIME_BITS-1:0] end_r;
  ibt_pkg::tok_t        tok_r;
  ibt_pkg::tok_t        tok_nxt;
  logic                 hit;

  always_comb begin
    hit = valid_r && !((end_r <= req_start) || (start_r >= req_end));
    tok_nxt.active    = tok_in.active;
    tok_nxt.clash     = tok_in.clash | (tok_in.active & hit);
    tok_nxt.free_seen = tok_in.free_seen | (tok_in.active & !valid_r);
    cand_nxt = tok_in.active ? (!valid_r && !tok_in.free_seen) : cand_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cand_r  <= 1'b0;
      tok_r   <= '0;
    end else begin
      tok_r  <= tok_nxt;
      cand_r <= cand_nxt;
      if (commit && cand_r) begin
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit && cand_r) begin
      start_r <= req_start;
      end_r   <= req_end;
    end
  end

  assign tok_out    = tok_r;
  assign slot_valid = valid_r;
  assign slot_cand  = cand_r;

endmodule
`default_nettype wire

### rtl/interval_booking_table_unit.sv
// top level: request control, chain of table cells and result register
// Each beat asks to book the half-open interval [start, end) in a table of
// TABLE_ENTRIES entries and returns one result beat with a status (booked,
// overlap, table full, invalid empty interval) and the entry count after it.
// One request is handled at a time: it walks the cell chain one cell per
// cycle, while an empty or reversed interval skips the chain and goes
// straight to the result. The result register lets a new request in while
// the previous result waits.
// Times are compared on their low TIME_BITS bits, unsigned.
`default_nettype none
module interval_booking_table_unit #(
  parameter int unsigned TABLE_ENTRIES = ibt_pkg::DefTableEntries,
  parameter int unsigned TIME_BITS     = ibt_pkg::DefTimeBits
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [ibt_pkg::InTimeW-1:0]   in_interval_start,
  input  wire logic [ibt_pkg::InTimeW-1:0]   in_interval_end,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         out_status,
  output logic [ibt_pkg::UsedW-1:0]          out_entries_used
);

  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  state_t                      state_r;
  logic [TIME_BITS-1:0]        req_start_r;
  logic [TIME_BITS-1:0]        req_end_r;
  ibt_pkg::tok_t               head_r;
  logic [CntW-1:0]             cnt_r;
  ibt_pkg::status_t            res_r;
  logic                        out_valid_r;
  ibt_pkg::status_t            out_status_r;
  logic [ibt_pkg::UsedW-1:0]   out_used_r;

  logic [TIME_BITS+ibt_pkg::InTimeW-1:0] lo_ext;
  logic [TIME_BITS+ibt_pkg::InTimeW-1:0] hi_ext;
  logic [TIME_BITS-1:0]                  lo;
  logic [TIME_BITS-1:0]                  hi;
  logic [CntW+ibt_pkg::UsedW-1:0]        cnt_ext;

  ibt_pkg::tok_t              tok [TABLE_ENTRIES+1];
  ibt_pkg::tok_t              tail;
  logic [TABLE_ENTRIES-1:0]   valid_vec;
  logic [TABLE_ENTRIES-1:0]   cand_vec;
  logic                       commit;

  assign lo_ext  = {{TIME_BITS{1'b0}}, in_interval_start};
  assign hi_ext  = {{TIME_BITS{1'b0}}, in_interval_end};
  assign lo      = lo_ext[TIME_BITS-1:0];
  assign hi      = hi_ext[TIME_BITS-1:0];
  assign cnt_ext = {{ibt_pkg::UsedW{1'b0}}, cnt_r};

  assign tok[0] = head_r;
  assign tail   = tok[TABLE_ENTRIES];
  assign commit = (state_r == S_SCAN) && tail.active && !tail.clash && tail.free_seen;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    ibt_cell #(
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .req_start  (req_start_r),
      .req_end    (req_end_r),
      .tok_in     (tok[i]),
      .tok_out    (tok[i+1]),
      .commit     (commit),
      .slot_valid (valid_vec[i]),
      .slot_cand  (cand_vec[i])
    );
  end

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r <= '0;
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_start_r <= lo;
            req_end_r   <= hi;
            if (hi <= lo) begin
              res_r   <= ibt_pkg::ST_INVALID;
              state_r <= S_DONE;
            end else begin
              head_r.active <= 1'b1;
              state_r       <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (tail.active) begin
            if (tail.clash) begin
              res_r <= ibt_pkg::ST_OVERLAP;
            end else if (!tail.free_seen) begin
              res_r <= ibt_pkg::ST_FULL;
            end else begin
              res_r <= ibt_pkg::ST_BOOKED;
              cnt_r <= cnt_r + CntW'(1);
            end
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_r;
            out_used_r   <= cnt_ext[ibt_pkg::UsedW-1:0];
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_entries_used = out_used_r;

`ifndef SYNTHESIS
  a_one_cand: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cand_vec))
    else $error("more than one insert target in the chain");

  a_cnt_match: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == CntW'($countones(valid_vec)))
    else $error("entry count differs from stored entries");

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    commit |-> $onehot(cand_vec))
    else $error("booking with no single free target entry");

  a_commit_grows: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> cnt_r == $past(cnt_r) + CntW'(1))
    else $error("booking did not raise the entry count");
`endif

endmodule
`default_nettype wire

### tb/tb.sv
// self-checking testbench for interval_booking_table_unit: interval booking against an own table
module tb;
  import ibt_pkg::*;

  localparam int unsigned TableEntries = DefTableEntries;
  localparam int unsigned TimeBits     = DefTimeBits;
  localparam int unsigned QuietLimit   = 2000;
  localparam int unsigned HoldAfter    = 300;
  localparam int unsigned HoldCycles   = 250;
  localparam int unsigned TailCycles   = 40;
  localparam int unsigned RandomReqs   = 1325;
  localparam int unsigned MaxPrinted   = 100;

  typedef struct {
    logic [InTimeW-1:0] lo;
    logic [InTimeW-1:0] hi;
  } request_t;

  typedef struct {
    status_t            status;
    logic [UsedW-1:0]   used;
  } outcome_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [InTimeW-1:0]   in_interval_start = '0;
  logic [InTimeW-1:0]   in_interval_end = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           out_status;
  logic [UsedW-1:0]     out_entries_used;

  request_t             pending_reqs[$];
  outcome_t             awaited_outcomes[$];
  logic [InTimeW-1:0]   anchor_lo[$];
  logic [InTimeW-1:0]   anchor_hi[$];

  logic [TimeBits-1:0]  table_lo[TableEntries];
  logic [TimeBits-1:0]  table_hi[TableEntries];
  logic                 table_used[TableEntries];
  int unsigned          table_count;

  int unsigned          err_count;
  int unsigned          quiet_cycles;

  interval_booking_table_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_interval_start(in_interval_start),
    .in_interval_end  (in_interval_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_entries_used (out_entries_used)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic flag_mismatch(input string msg);
    if (err_count < MaxPrinted) begin
      $display("mismatch: %s", msg);
    end
    err_count++;
  endtask

  // booking decision for one accepted beat, updates the shadow table
  task automatic book_interval(input logic [InTimeW-1:0] req_lo,
                               input logic [InTimeW-1:0] req_hi);
    logic [TimeBits-1:0] lo;
    logic [TimeBits-1:0] hi;
    logic                clash;
    int                  free_slot;
    outcome_t            res;
    lo = req_lo[TimeBits-1:0];
    hi = req_hi[TimeBits-1:0];
    clash = 1'b0;
    free_slot = -1;
    if (hi <= lo) begin
      res.status = ST_INVALID;
    end else begin
      for (int i = 0; i < TableEntries; i++) begin
        if (table_used[i]) begin
          if (!(table_hi[i] <= lo || table_lo[i] >= hi)) clash = 1'b1;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (clash) begin
        res.status = ST_OVERLAP;
      end else if (free_slot < 0) begin
        res.status = ST_FULL;
      end else begin
        table_lo[free_slot] = lo;
        table_hi[free_slot] = hi;
        table_used[free_slot] = 1'b1;
        table_count++;
        res.status = ST_BOOKED;
      end
    end
    res.used = table_count[UsedW-1:0];
    awaited_outcomes.push_back(res);
  endtask

  task automatic queue_req(input logic [InTimeW-1:0] lo, input logic [InTimeW-1:0] hi);
    request_t r;
    r.lo = lo;
    r.hi = hi;
    pending_reqs.push_back(r);
  endtask

  task automatic queue_booking(input logic [InTimeW-1:0] lo, input logic [InTimeW-1:0] hi);
    queue_req(lo, hi);
    anchor_lo.push_back(lo);
    anchor_hi.push_back(hi);
  endtask

  // sender: bursts of random length with random gaps
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk) begin : req_driver
    request_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        book_interval(in_interval_start, in_interval_end);
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          r = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_interval_start <= r.lo;
          in_interval_end <= r.hi;
          if (burst_left == 0) burst_left = $urandom_range(1, 30);
          burst_left--;
          if (burst_left == 0) begin
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern of its own plus one long hold-off
  int unsigned results_seen;
  int unsigned hold_left;
  int unsigned rdy_mode;
  int unsigned mode_left;
  int unsigned stall_tick;

  always @(posedge clk) begin : result_monitor
    outcome_t want;
    logic     nxt_rdy;
    if (!rst_n) begin
      out_ready <= 1'b0;
      results_seen = 0;
      hold_left = 0;
      mode_left = 0;
      stall_tick = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (awaited_outcomes.size() == 0) begin
          flag_mismatch($sformatf("unexpected beat status=%0d used=%0d",
                                  out_status, out_entries_used));
        end else begin
          want = awaited_outcomes.pop_front();
          if (out_status !== want.status) begin
            flag_mismatch($sformatf("beat %0d status %0d, want %s", results_seen,
                                    out_status, want.status.name()));
          end
          if (out_entries_used !== want.used) begin
            flag_mismatch($sformatf("beat %0d entries_used %0d, want %0d", results_seen,
                                    out_entries_used, want.used));
          end
        end
        if (results_seen == HoldAfter) hold_left = HoldCycles;
      end
      if (mode_left == 0) begin
        rdy_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      stall_tick++;
      if (hold_left != 0) begin
        hold_left--;
        nxt_rdy = 1'b0;
      end else begin
        case (rdy_mode)
          0: nxt_rdy = 1'b1;
          1: nxt_rdy = $urandom_range(0, 1);
          2: nxt_rdy = (stall_tick % 3 == 0);
          default: nxt_rdy = ($urandom_range(0, 4) == 0);
        endcase
      end
      out_ready <= nxt_rdy;
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned         pick;
    int unsigned         len;
    int unsigned         j;
    logic [InTimeW-1:0]  a;
    logic [InTimeW-1:0]  b;
    err_count = 0;
    table_count = 0;
    quiet_cycles = 0;
    for (int i = 0; i < TableEntries; i++) begin
      table_used[i] = 1'b0;
      table_lo[i] = '0;
      table_hi[i] = '0;
    end

    // empty and reversed intervals
    queue_req(32'd0, 32'd0);
    queue_req(32'hFFFF_FFFF, 32'd0);
    queue_req(32'd5, 32'd5);
    // touching intervals and overlaps at the extremes
    queue_booking(32'd0, 32'd100);
    queue_booking(32'd100, 32'd200);
    queue_req(32'd50, 32'd150);
    queue_booking(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    queue_req(32'd0, 32'hFFFF_FFFF);
    queue_req(32'd99, 32'd101);
    queue_booking(32'd200, 32'd300);
    queue_req(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // fill the table
    for (int k = 1; k <= TableEntries - 4; k++) begin
      queue_booking(32'(k * 1000), 32'(k * 1000 + 10));
    end
    // full table, overlap while full, invalid while full
    queue_req(32'd500000, 32'd500010);
    queue_req(32'd150, 32'd160);
    queue_req(32'd10, 32'd5);

    for (int n = 0; n < RandomReqs; n++) begin
      pick = $urandom_range(0, 9);
      len = $urandom_range(1, 20);
      a = $urandom;
      b = $urandom;
      if (pick == 0) begin
        if (a >= b) queue_req(a, b);
        else queue_req(b, a);
      end else if (pick <= 5) begin
        // near the edges of a stored interval
        j = $urandom_range(0, anchor_lo.size() - 1);
        if ($urandom_range(0, 1) == 1) begin
          a = anchor_hi[j] + $urandom_range(0, 4) - 2;
          queue_req(a, a + len);
        end else begin
          b = anchor_lo[j] + $urandom_range(0, 4) - 2;
          queue_req(b - len, b);
        end
      end else if (pick <= 7) begin
        queue_req(a, a + len);
      end else begin
        queue_req(a, b);
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || in_valid || awaited_outcomes.size() != 0) begin
      @(posedge clk);
    end
    repeat (TailCycles) @(posedge clk);
    if (awaited_outcomes.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", awaited_outcomes.size()));
    end
    if (err_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
